[hdl/assert_macros.svh]
// assertion macros used by the top level rtl file
// no dependencies; each macro compiles to nothing when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[hdl/annb_pkg.sv]
// shared types and constants of the length-prefixed to annex b converter
// no dependencies
package annb_pkg;

  localparam int MAX_LENGTH_BYTES_DEF = 4;
  localparam int CMD_DEPTH_DEF        = 4;
  localparam int LEN_W                = 3;
  localparam int HDR_W                = 3;
  localparam logic [LEN_W-1:0] LEN_RESET = 3'd4;
  localparam logic [HDR_W-1:0] HDR_SAT   = 3'd7;
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  typedef enum logic [1:0] {
    CMD_PAY,
    CMD_MARK,
    CMD_START
  } cmd_kind_t;

  // one classified input byte, queued between front and back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        stream_end;
    logic        truncated;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       run_last;
    logic       stream_end;
    logic       truncated;
  } res_t;

  // front parser status
  typedef struct packed {
    logic in_payload;
    logic hdr_zero;
  } front_stat_t;

  // back expander status
  typedef struct packed {
    logic start_busy;
    logic fire;
  } back_stat_t;

endpackage

[hdl/annb_front.sv]
// front parser: gathers length fields, counts payload, classifies each byte
// depends on annb_pkg
module annb_front #(
  parameter int MAX_LENGTH_BYTES = annb_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic [7:0]                   in_byte,
  input  logic                         in_is_last,
  input  logic [annb_pkg::LEN_W-1:0]   len_cfg,
  output logic                         cmd_valid,
  output annb_pkg::cmd_t               cmd,
  output annb_pkg::front_stat_t        stat
);
  import annb_pkg::*;

  localparam int NW = 8 * MAX_LENGTH_BYTES;

  logic            in_payload_r, in_payload_nxt;
  logic [HDR_W-1:0] hdr_r, hdr_nxt, hdr_inc;
  logic [NW-1:0]   nal_r, nal_nxt, nal_dec, nal_shift;
  logic [LEN_W-1:0] eff_len;

  // clamp the prefix width to 1..max
  always_comb begin
    if (len_cfg == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_cfg > LEN_W'(MAX_LENGTH_BYTES)) begin
      eff_len = LEN_W'(MAX_LENGTH_BYTES);
    end else begin
      eff_len = len_cfg;
    end
  end

  assign nal_dec   = nal_r - NW'(1);
  assign nal_shift = (nal_r << 8) | NW'(in_byte);
  assign hdr_inc   = (hdr_r < HDR_SAT) ? hdr_r + HDR_W'(1) : hdr_r;

  // classify the accepted byte and work out the next parser state
  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_nxt        = hdr_r;
    nal_nxt        = nal_r;
    cmd_valid      = 1'b0;
    cmd.kind       = CMD_PAY;
    cmd.data       = in_byte;
    cmd.stream_end = 1'b0;
    cmd.truncated  = 1'b0;
    if (acc) begin
      if (in_payload_r) begin
        cmd_valid = 1'b1;
        if (in_is_last) begin
          cmd.stream_end = 1'b1;
          cmd.truncated  = (nal_dec != '0);
          in_payload_nxt = 1'b0;
          hdr_nxt        = '0;
          nal_nxt        = '0;
        end else begin
          nal_nxt = nal_dec;
          if (nal_dec == '0) begin
            in_payload_nxt = 1'b0;
            hdr_nxt        = '0;
          end
        end
      end else if (in_is_last) begin
        // header cut off or complete at stream end: end marker only
        cmd_valid      = 1'b1;
        cmd.kind       = CMD_MARK;
        cmd.data       = SC_ZERO;
        cmd.stream_end = 1'b1;
        hdr_nxt        = '0;
        nal_nxt        = '0;
      end else if (hdr_inc < eff_len) begin
        hdr_nxt = hdr_inc;
        nal_nxt = nal_shift;
      end else begin
        cmd_valid      = 1'b1;
        cmd.kind       = CMD_START;
        hdr_nxt        = '0;
        nal_nxt        = nal_shift;
        in_payload_nxt = (nal_shift != '0);
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_r        <= '0;
      nal_r        <= '0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_r        <= hdr_nxt;
      nal_r        <= nal_nxt;
    end
  end

  assign stat.in_payload = in_payload_r;
  assign stat.hdr_zero   = (hdr_r == '0);

endmodule

[hdl/annb_cmd_fifo.sv]
// short command queue between front parser and back expander
// depends on annb_pkg
module annb_cmd_fifo #(
  parameter int DEPTH = annb_pkg::CMD_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  annb_pkg::cmd_t  wr_cmd,
  input  logic            rd_en,
  output annb_pkg::cmd_t  rd_cmd,
  output logic            full,
  output logic            empty
);
  import annb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign rd_cmd = mem[rp_r];
  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);

endmodule

[hdl/annb_back.sv]
// back expander: turns queued commands into result items, a start code into
// four items 00 00 00 01; holds the output register; depends on annb_pkg
module annb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  annb_pkg::cmd_t        head,
  input  logic                  head_valid,
  output logic                  head_pop,
  input  logic                  out_pop,
  output logic                  out_valid,
  output annb_pkg::res_t        res,
  output annb_pkg::back_stat_t  stat
);
  import annb_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r;
  res_t       res_r, res_nxt;
  logic       fire;

  // a head command waits and the output slot is free or being emptied this cycle
  assign fire = head_valid && (!valid_r || out_pop);

  // build the next result from the head command
  always_comb begin
    res_nxt  = '0;
    idx_nxt  = idx_r;
    head_pop = 1'b0;
    unique case (head.kind)
      CMD_PAY: begin
        res_nxt.data_byte  = head.data;
        res_nxt.has_byte   = 1'b1;
        res_nxt.run_last   = 1'b1;
        res_nxt.stream_end = head.stream_end;
        res_nxt.truncated  = head.truncated;
        head_pop           = fire;
      end
      CMD_MARK: begin
        res_nxt.run_last   = 1'b1;
        res_nxt.stream_end = 1'b1;
        head_pop           = fire;
      end
      CMD_START: begin
        res_nxt.data_byte = (idx_r == 2'd3) ? SC_ONE : SC_ZERO;
        res_nxt.has_byte  = 1'b1;
        res_nxt.run_last  = (idx_r == 2'd3);
        head_pop          = fire && (idx_r == 2'd3);
        if (fire) begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      default: begin
        head_pop = fire;
      end
    endcase
  end

  // output register and start code position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (fire) begin
        valid_r <= 1'b1;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign res             = res_r;
  assign stat.start_busy = (idx_r != 2'd0);
  assign stat.fire       = fire;

endmodule

[hdl/length_prefixed_to_annexb_nal_top.sv]
// top level of the length-prefixed to annex b nal converter
// depends on annb_pkg, annb_front, annb_cmd_fifo, annb_back, assert_macros.svh

// Converts a byte stream of NAL units with big-endian length prefixes
// (cfg_data sets 1..4 prefix bytes, reset 4, 0 acts as 1) into Annex B form:
// every length field completed before stream end produces 00 00 00 01, then
// the payload bytes pass through. A payload byte or end marker makes one result
// item, a start code four items, a length byte that completes nothing none; the
// input side takes one byte every cycle until the command queue (CMD_DEPTH
// entries) fills, as it can behind a start code or a stalled result side. The
// configuration port is always ready and must only be written while the block
// has no results pending. A stream cut inside a payload ends with truncated set
// on the stream_end result; after stream end the parser is back at its reset state.
`include "assert_macros.svh"

module length_prefixed_to_annexb_nal_top #(
  parameter int MAX_LENGTH_BYTES = annb_pkg::MAX_LENGTH_BYTES_DEF,
  parameter int CMD_DEPTH        = annb_pkg::CMD_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_byte,
  input  logic                        in_is_last,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_data_byte,
  output logic                        out_has_byte,
  output logic                        out_run_last,
  output logic                        out_stream_end,
  output logic                        out_truncated,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [annb_pkg::LEN_W-1:0]  cfg_data
);
  import annb_pkg::*;

  logic [LEN_W-1:0] len_r;
  logic             acc;
  logic             cmd_valid;
  cmd_t             cmd, head;
  logic             q_full, q_empty, head_pop;
  logic             out_valid;
  res_t             res;
  front_stat_t      fstat;
  back_stat_t       bstat;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      len_r <= cfg_data;
    end
  end

  assign acc  = push && !q_full;
  assign full = q_full;

  annb_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_is_last(in_is_last),
    .len_cfg   (len_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .stat      (fstat)
  );

  annb_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cmd_valid),
    .wr_cmd(cmd),
    .rd_en (head_pop),
    .rd_cmd(head),
    .full  (q_full),
    .empty (q_empty)
  );

  annb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_valid(!q_empty),
    .head_pop  (head_pop),
    .out_pop   (pop),
    .out_valid (out_valid),
    .res       (res),
    .stat      (bstat)
  );

  // result ports
  assign empty          = !out_valid;
  assign out_data_byte  = res.data_byte;
  assign out_has_byte   = res.has_byte;
  assign out_run_last   = res.run_last;
  assign out_stream_end = res.stream_end;
  assign out_truncated  = res.truncated;

  // checks
  `ASSERT_CLK(a_end_clears, clk, rst_n, (acc && in_is_last) |=> (!fstat.in_payload && fstat.hdr_zero))
  `ASSERT_CLK(a_start_head, clk, rst_n, bstat.start_busy |-> (!q_empty && head.kind == CMD_START))
  `ASSERT_CLK(a_marker_form, clk, rst_n, (out_valid && !res.has_byte) |-> (res.data_byte == SC_ZERO && res.stream_end && res.run_last && !res.truncated))
  `ASSERT_NEVER(a_fire_no_head, clk, rst_n, bstat.fire && q_empty)

endmodule

[bench/annb_checker.sv]
// checker for the length-prefixed to annex b converter: predicts and compares results
// depends on annb_pkg for the result type, the start code and the width constants
module annb_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic                        full,
  input  logic [7:0]                  in_byte,
  input  logic                        in_is_last,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [7:0]                  out_data_byte,
  input  logic                        out_has_byte,
  input  logic                        out_run_last,
  input  logic                        out_stream_end,
  input  logic                        out_truncated,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [annb_pkg::LEN_W-1:0]  cfg_data,
  output int unsigned                 n_fail,
  output int unsigned                 pending
);
  import annb_pkg::*;

  // mirror of the converter state and its prefix width register
  logic [LEN_W-1:0] prefix_len;
  logic             payload_mode;
  logic [HDR_W-1:0] hdr_count;
  logic [31:0]      nal_left;

  res_t        annexb_due_q[$];
  int unsigned bad_count;

  function automatic res_t mk_res(logic [7:0] b, logic has, logic rl, logic se, logic tr);
    res_t r;
    r.data_byte  = b;
    r.has_byte   = has;
    r.run_last   = rl;
    r.stream_end = se;
    r.truncated  = tr;
    return r;
  endfunction

  // one accepted input byte: update the mirror, queue the annex b bytes it causes
  task automatic convert_byte(input logic [7:0] b, input logic last);
    int eff;
    eff = (prefix_len == 0) ? 1 :
          (int'(prefix_len) > MAX_LENGTH_BYTES_DEF) ? MAX_LENGTH_BYTES_DEF : int'(prefix_len);
    if (payload_mode) begin
      nal_left = nal_left - 32'd1;
      if (last) begin
        annexb_due_q.push_back(mk_res(b, 1'b1, 1'b1, 1'b1, nal_left != 0));
        payload_mode = 1'b0;
        hdr_count    = '0;
        nal_left     = '0;
      end else begin
        annexb_due_q.push_back(mk_res(b, 1'b1, 1'b1, 1'b0, 1'b0));
        if (nal_left == 0) begin
          payload_mode = 1'b0;
          hdr_count    = '0;
        end
      end
    end else begin
      nal_left = {nal_left[23:0], b};
      if (hdr_count < HDR_SAT) hdr_count = hdr_count + 1'b1;
      if (last) begin
        // length field dropped at stream end: bare end marker
        annexb_due_q.push_back(mk_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
        payload_mode = 1'b0;
        hdr_count    = '0;
        nal_left     = '0;
      end else if (int'(hdr_count) >= eff) begin
        annexb_due_q.push_back(mk_res(SC_ZERO, 1'b1, 1'b0, 1'b0, 1'b0));
        annexb_due_q.push_back(mk_res(SC_ZERO, 1'b1, 1'b0, 1'b0, 1'b0));
        annexb_due_q.push_back(mk_res(SC_ZERO, 1'b1, 1'b0, 1'b0, 1'b0));
        annexb_due_q.push_back(mk_res(SC_ONE,  1'b1, 1'b1, 1'b0, 1'b0));
        hdr_count = '0;
        // zero-length unit goes straight back to the next length field
        if (nal_left != 0) payload_mode = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      prefix_len   = LEN_RESET;
      payload_mode = 1'b0;
      hdr_count    = '0;
      nal_left     = '0;
      bad_count    = 0;
      annexb_due_q.delete();
    end else begin
      // result transaction against the oldest expected byte
      if (pop && !empty) begin
        if (annexb_due_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected result: byte %h has %b rl %b se %b tr %b", out_data_byte,
                     out_has_byte, out_run_last, out_stream_end, out_truncated);
        end else begin
          exp_r = annexb_due_q.pop_front();
          if (exp_r.data_byte !== out_data_byte || exp_r.has_byte !== out_has_byte ||
              exp_r.run_last !== out_run_last || exp_r.stream_end !== out_stream_end ||
              exp_r.truncated !== out_truncated) begin
            bad_count++;
            if (bad_count <= 10)
              $display("mismatch: exp byte %h has %b rl %b se %b tr %b, ",
                       exp_r.data_byte, exp_r.has_byte, exp_r.run_last, exp_r.stream_end,
                       exp_r.truncated,
                       "got byte %h has %b rl %b se %b tr %b",
                       out_data_byte, out_has_byte, out_run_last,
                       out_stream_end, out_truncated);
          end
        end
      end
      // register write transaction
      if (cfg_valid && cfg_ready) prefix_len = cfg_data;
      // input transaction
      if (push && !full) convert_byte(in_byte, in_is_last);
    end
    n_fail  <= bad_count;
    pending <= annexb_due_q.size();
  end

endmodule

[bench/tb_top.sv]
// testbench top for length_prefixed_to_annexb_nal_top: stimulus, idling and verdict
// depends on annb_pkg, the converter rtl and annb_checker
module tb_top;
  import annb_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } in_item_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                push;
  logic                full;
  logic [7:0]          in_byte;
  logic                in_is_last;
  logic                empty;
  logic                pop;
  logic [7:0]          out_data_byte;
  logic                out_has_byte;
  logic                out_run_last;
  logic                out_stream_end;
  logic                out_truncated;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_data;
  int unsigned         n_fail;
  int unsigned         pending;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          hold_req  = 1'b0;
  int unsigned items_sent = 0;
  in_item_t    stream_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  length_prefixed_to_annexb_nal_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .in_is_last     (in_is_last),
    .empty          (empty),
    .pop            (pop),
    .out_data_byte  (out_data_byte),
    .out_has_byte   (out_has_byte),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end),
    .out_truncated  (out_truncated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  annb_checker i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .in_is_last     (in_is_last),
    .empty          (empty),
    .pop            (pop),
    .out_data_byte  (out_data_byte),
    .out_has_byte   (out_has_byte),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end),
    .out_truncated  (out_truncated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .n_fail         (n_fail),
    .pending        (pending)
  );

  // offer one byte, with random gaps first, until the input transaction happens
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // stop offering, let every expected byte come out, then let the parser settle
  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one stream: mostly well-formed units, ending cleanly, truncated, in a header or as noise
  task automatic build_stream(input int lb);
    int          n_units;
    int          ending;
    int          plen;
    int          keep;
    int          u;
    int          i;
    logic [31:0] hdr_val;
    stream_q.delete();
    ending = $urandom_range(0, 9);
    if (ending == 9) begin
      n_units = $urandom_range(1, 10);
      repeat (n_units) stream_q.push_back(in_item_t'{b: 8'($urandom), last: 1'b0});
    end else begin
      n_units = $urandom_range(1, 4);
      for (u = 0; u < n_units; u++) begin
        plen = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        hdr_val = plen;
        keep = plen;
        if (u == n_units - 1 && ending == 6) begin
          // payload cut by stream end, sometimes behind a wild length
          if ($urandom_range(1) == 1) begin
            hdr_val = $urandom;
            keep = $urandom_range(1, 6);
          end else begin
            plen = $urandom_range(2, 40);
            hdr_val = plen;
            keep = $urandom_range(1, plen - 1);
          end
        end else if (u == n_units - 1 && ending == 8) begin
          hdr_val = $urandom;
          keep = 0;
        end
        if (u == n_units - 1 && ending == 7 && lb > 1) begin
          // stream ends inside the length field
          repeat ($urandom_range(1, lb - 1))
            stream_q.push_back(in_item_t'{b: 8'($urandom), last: 1'b0});
        end else begin
          for (i = lb - 1; i >= 0; i--)
            stream_q.push_back(in_item_t'{b: hdr_val[8*i +: 8], last: 1'b0});
          repeat (keep) stream_q.push_back(in_item_t'{b: 8'($urandom), last: 1'b0});
        end
      end
    end
    stream_q[stream_q.size() - 1].last = 1'b1;
  endtask

  task automatic run_segment(input logic [LEN_W-1:0] cfg, input int unsigned n_items);
    int unsigned start;
    int          lb;
    in_item_t    it;
    wait_idle();
    write_len(cfg);
    lb = (cfg == 0) ? 1 : (int'(cfg) > MAX_LENGTH_BYTES_DEF) ? MAX_LENGTH_BYTES_DEF : int'(cfg);
    start = items_sent;
    while (items_sent - start < n_items) begin
      build_stream(lb);
      while (stream_q.size() != 0) begin
        it = stream_q.pop_front();
        send_byte(it.b, it.last);
      end
    end
  endtask

  // receiver: random pops, with one long hold-off on request
  initial begin
    pop = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (80) begin
          pop <= 1'b0;
          @(posedge clk);
        end
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
        @(posedge clk);
      end
    end
  end

  initial begin
    #400000;
    $display("length_prefixed_to_annexb_nal_top verification failed");
    $finish;
  end

  // main stimulus
  initial begin
    rst_n      = 1'b0;
    push       = 1'b0;
    in_byte    = 8'h00;
    in_is_last = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset prefix width of four
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
    // zero-length unit
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    // payload cut short
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h02, 1'b0);
    send_byte(8'hAA, 1'b1);
    // header dropped partway at stream end
    send_byte(8'h12, 1'b0); send_byte(8'h34, 1'b1);
    // header dropped on its completing byte
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h05, 1'b1);
    // width narrowed mid-field lets the next length byte complete the field
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    wait_idle();
    write_len(3'd2);
    send_byte(8'h01, 1'b0); send_byte(8'h7E, 1'b1);

    // random, sender idles lightly, receiver heavily
    send_idle = 21;
    recv_idle = 88;
    run_segment(3'd1, 30);
    run_segment(3'd4, 30);
    run_segment(3'd0, 30);
    // the other way round
    send_idle = 88;
    recv_idle = 21;
    run_segment(3'd2, 30);
    run_segment(3'd7, 30);
    run_segment(3'd3, 30);
    // no idling, with one long receiver hold-off while the sender keeps offering
    send_idle = 0;
    recv_idle = 0;
    wait_idle();
    hold_req  = 1'b1;
    run_segment(3'd5, 30);
    run_segment(3'd6, 30);
    run_segment(3'd4, 30);

    wait_idle();
    repeat (20) @(posedge clk);
    if (n_fail == 0) begin
      $display("length_prefixed_to_annexb_nal_top verification clean");
    end else begin
      $display("length_prefixed_to_annexb_nal_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/annb_pkg.sv
hdl/annb_front.sv
hdl/annb_cmd_fifo.sv
hdl/annb_back.sv
hdl/length_prefixed_to_annexb_nal_top.sv
bench/annb_checker.sv
bench/tb_top.sv
